@@ rtl/first_fit_semispace_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the semispace allocator
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_SEMISPACE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SEMISPACE_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
`define FFSS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ffss assertion failed");
`define FFSS_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ffss assertion failed");
`else
`define FFSS_ASSERT(lbl, clk, rst_n, prop)
`define FFSS_ASSERT_NR(lbl, clk, prop)
`endif

`endif

@@ rtl/ffss_pkg.sv @@
// ----------------------------------------------------------------------------
// ffss_pkg
// Types and constants shared by the semispace allocator.
// ----------------------------------------------------------------------------
package ffss_pkg;

  localparam int HALF_WORDS    = 4096;
  localparam int TABLE_ENTRIES = 64;

  localparam int OFF_W   = 12;
  localparam int LEN_W   = 13;
  localparam int CNT_W   = 7;
  localparam int BYTES_W = 16;
  localparam int WORDS_W = 14;

  // Per-space state: the single free chunk and the allocation count.
  typedef struct packed {
    logic             free_valid;
    logic [OFF_W-1:0] free_start;
    logic [LEN_W-1:0] free_len;
    logic [CNT_W-1:0] used_cnt;
  } space_ent_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_ALLOC,
    ST_DONE
  } state_e;

  function automatic space_ent_t fresh_space();
    space_ent_t e;
    e.free_valid = 1'b1;
    e.free_start = '0;
    e.free_len   = LEN_W'(HALF_WORDS);
    e.used_cnt   = '0;
    return e;
  endfunction

endpackage

@@ rtl/ffss_space_ram.sv @@
// ----------------------------------------------------------------------------
// ffss_space_ram
// Two-entry space state memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffss_space_ram (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic               wr_addr_i,
  input  ffss_pkg::space_ent_t wr_data_i,
  input  logic               rd_en_i,
  input  logic               rd_addr_i,
  output ffss_pkg::space_ent_t rd_data_o
);
  import ffss_pkg::*;

  space_ent_t mem [2];
  space_ent_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/first_fit_semispace_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_semispace_allocator
// First-fit word allocator over two half spaces with flip on exhaustion.
// ----------------------------------------------------------------------------
//  channel | valid       | stall       | data
//  input   | in_valid_i  | in_stall_o  | request_bytes_i
//  output  | out_valid_o | out_stall_i | granted, space_used, word_offset,
//          |             |             | granted_words, flipped
//
// A request passes through accept with space memory read, flip check,
// allocate and output load, in that order.
// The registered space memory read sets the step order.
// After reset a clearing pass initializes both spaces; stall is high.
// A new word is taken while a result still waits at the output; a second
// result holds the load step, and input stall, until the output is taken.
// ----------------------------------------------------------------------------
`include "first_fit_semispace_allocator_macros.svh"

module first_fit_semispace_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ffss_pkg::BYTES_W-1:0] request_bytes_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         granted_o,
  output logic                         space_used_o,
  output logic [ffss_pkg::OFF_W-1:0]   word_offset_o,
  output logic [ffss_pkg::LEN_W-1:0]   granted_words_o,
  output logic                         flipped_o
);
  import ffss_pkg::*;

  state_e state_q, state_d;
  logic   clr_idx_q, clr_idx_d;
  logic   active_q, active_d;
  logic   flip_q, flip_d;
  logic [WORDS_W-1:0] words_q, words_d;

  logic             res_grant_q, res_grant_d;
  logic             res_space_q, res_space_d;
  logic [OFF_W-1:0] res_off_q, res_off_d;
  logic [LEN_W-1:0] res_len_q, res_len_d;
  logic             res_flip_q, res_flip_d;

  logic             out_valid_q, out_valid_d;
  logic             out_grant_q, out_space_q, out_flip_q;
  logic [OFF_W-1:0] out_off_q;
  logic [LEN_W-1:0] out_len_q;
  logic             out_load;

  logic       wr_en, wr_addr, rd_en, rd_addr;
  space_ent_t wr_data, rd_data, upd;
  logic       in_acc, fit, need_flip;

  ffss_space_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign need_flip = (rd_data.used_cnt >= CNT_W'(TABLE_ENTRIES)) || !rd_data.free_valid;
  assign fit = (rd_data.used_cnt < CNT_W'(TABLE_ENTRIES)) && rd_data.free_valid &&
               ({1'b0, rd_data.free_len} >= words_q);

  always_comb begin
    upd            = rd_data;
    upd.free_start = rd_data.free_start + words_q[OFF_W-1:0];
    upd.free_len   = rd_data.free_len - words_q[LEN_W-1:0];
    upd.free_valid = (rd_data.free_len != words_q[LEN_W-1:0]);
    upd.used_cnt   = rd_data.used_cnt + CNT_W'(1);
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    active_d    = active_q;
    flip_d      = flip_q;
    words_d     = words_q;
    res_grant_d = res_grant_q;
    res_space_d = res_space_q;
    res_off_d   = res_off_q;
    res_len_d   = res_len_q;
    res_flip_d  = res_flip_q;
    wr_en       = 1'b0;
    wr_addr     = active_q;
    wr_data     = fresh_space();
    rd_en       = 1'b0;
    rd_addr     = active_q;
    case (state_q)
      ST_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = clr_idx_q;
        clr_idx_d = 1'b1;
        if (clr_idx_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          words_d = WORDS_W'(({1'b0, request_bytes_i} + 17'd7) >> 3);
          flip_d  = 1'b0;
          rd_en   = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (words_q == '0) begin
          res_grant_d = 1'b0;
          res_space_d = active_q;
          res_off_d   = '0;
          res_len_d   = '0;
          res_flip_d  = 1'b0;
          state_d     = ST_DONE;
        end else begin
          if (need_flip) begin
            wr_en    = 1'b1;
            active_d = ~active_q;
            flip_d   = 1'b1;
            rd_en    = 1'b1;
            rd_addr  = ~active_q;
          end
          state_d = ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        if (fit) begin
          wr_en   = 1'b1;
          wr_data = upd;
        end
        res_grant_d = fit;
        res_space_d = active_q;
        res_off_d   = fit ? rd_data.free_start : '0;
        res_len_d   = fit ? words_q[LEN_W-1:0] : '0;
        res_flip_d  = flip_q;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= 1'b0;
      active_q    <= 1'b0;
      flip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      active_q    <= active_d;
      flip_q      <= flip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    words_q     <= words_d;
    res_grant_q <= res_grant_d;
    res_space_q <= res_space_d;
    res_off_q   <= res_off_d;
    res_len_q   <= res_len_d;
    res_flip_q  <= res_flip_d;
    if (out_load) begin
      out_grant_q <= res_grant_q;
      out_space_q <= res_space_q;
      out_off_q   <= res_off_q;
      out_len_q   <= res_len_q;
      out_flip_q  <= res_flip_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_o       = out_grant_q;
  assign space_used_o    = out_space_q;
  assign word_offset_o   = out_off_q;
  assign granted_words_o = out_len_q;
  assign flipped_o       = out_flip_q;

  `FFSS_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_acc |=> in_stall_o)
  `FFSS_ASSERT(a_grant_len, clk_i, rst_ni, (out_valid_o && granted_o) |-> (granted_words_o != '0))
  `FFSS_ASSERT(a_fail_zero, clk_i, rst_ni, (out_valid_o && !granted_o) |-> (word_offset_o == '0 && granted_words_o == '0))
  `FFSS_ASSERT_NR(a_reset_clear, clk_i, !rst_ni |=> (state_q == ST_CLEAR || !rst_ni))

endmodule

@@ tb/first_fit_semispace_allocator_checker.sv @@
// ----------------------------------------------------------------------------
// first_fit_semispace_allocator_checker
// Watches both channels of the allocator. Each accepted request is run
// through a local first-fit model with two half spaces. The expected grant
// is queued and then compared field by field with the next result taken.
// ----------------------------------------------------------------------------
module first_fit_semispace_allocator_checker
  import ffss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [BYTES_W-1:0] request_bytes_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               granted_i,
  input  logic               space_used_i,
  input  logic [OFF_W-1:0]   word_offset_i,
  input  logic [LEN_W-1:0]   granted_words_i,
  input  logic               flipped_i,
  output int                 errors_o,
  output int                 pending_o
);

  typedef struct packed {
    logic             granted;
    logic             space;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] words;
    logic             flipped;
  } grant_t;

  grant_t grants_due[$];

  logic             cur_space;
  logic [OFF_W-1:0] hole_start [2][TABLE_ENTRIES];
  logic [LEN_W-1:0] hole_len   [2][TABLE_ENTRIES];
  int               hole_cnt   [2];
  int               alloc_cnt  [2];

  function automatic void wipe_space(int s);
    hole_start[s][0] = '0;
    hole_len[s][0]   = LEN_W'(HALF_WORDS);
    hole_cnt[s]      = 1;
    alloc_cnt[s]     = 0;
  endfunction

  // Returns the grant for one request and advances the local heap state.
  function automatic grant_t allocate(logic [BYTES_W-1:0] nbytes);
    grant_t           g;
    int               words;
    int               s;
    int               k;
    int               j;
    logic [OFF_W-1:0] base;
    int               rest;
    g     = '0;
    words = (int'(nbytes) + 7) / 8;
    if (words > 0) begin
      s = cur_space;
      if (alloc_cnt[s] >= TABLE_ENTRIES || hole_cnt[s] == 0) begin
        cur_space = ~cur_space;
        wipe_space(s);
        g.flipped = 1'b1;
      end
      s = cur_space;
      if (alloc_cnt[s] < TABLE_ENTRIES) begin
        for (k = 0; k < hole_cnt[s]; k++) begin
          if (int'(hole_len[s][k]) >= words) begin
            base = hole_start[s][k];
            rest = int'(hole_len[s][k]) - words;
            for (j = k; j + 1 < hole_cnt[s]; j++) begin
              hole_start[s][j] = hole_start[s][j+1];
              hole_len[s][j]   = hole_len[s][j+1];
            end
            hole_cnt[s]--;
            alloc_cnt[s]++;
            if (rest > 0 && hole_cnt[s] < TABLE_ENTRIES) begin
              j = hole_cnt[s];
              while (j > 0 && int'(hole_start[s][j-1]) > int'(base) + words) begin
                hole_start[s][j] = hole_start[s][j-1];
                hole_len[s][j]   = hole_len[s][j-1];
                j--;
              end
              hole_start[s][j] = OFF_W'(int'(base) + words);
              hole_len[s][j]   = LEN_W'(rest);
              hole_cnt[s]++;
            end
            g.granted = 1'b1;
            g.offset  = base;
            g.words   = LEN_W'(words);
            break;
          end
        end
      end
    end
    g.space = cur_space;
    return g;
  endfunction

  assign pending_o = grants_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t seen;
    grant_t want;
    if (!rst_ni) begin
      grants_due.delete();
      cur_space = 1'b0;
      wipe_space(0);
      wipe_space(1);
      errors_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen = '{granted_i, space_used_i, word_offset_i, granted_words_i, flipped_i};
        if (grants_due.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("unexpected result word: %p", seen);
        end else begin
          want = grants_due.pop_front();
          if (seen !== want) begin
            errors_o++;
            if (errors_o <= 10)
              $display("mismatch: expected %p actual %p", want, seen);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        grants_due.push_back(allocate(request_bytes_i));
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Regression for the semispace allocator. Directed edge requests are
// followed by random requests in four phases of sender idling and receiver
// stall. The random mix uses mostly small sizes so that allocation tables
// fill and the half spaces flip. A checker beside the block scores results.
// ----------------------------------------------------------------------------
module tb;
  import ffss_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [BYTES_W-1:0] request_bytes_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               granted_o;
  logic               space_used_o;
  logic [OFF_W-1:0]   word_offset_o;
  logic [LEN_W-1:0]   granted_words_o;
  logic               flipped_o;

  int errors;
  int pending;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  first_fit_semispace_allocator u_dut (.*);

  first_fit_semispace_allocator_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .request_bytes_i,
    .out_valid_i(out_valid_o), .out_stall_i, .granted_i(granted_o),
    .space_used_i(space_used_o), .word_offset_i(word_offset_o),
    .granted_words_i(granted_words_o), .flipped_i(flipped_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i)
    out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 4000) begin
      $display("first_fit_semispace_allocator regression: fail");
      $finish;
    end
  end

  task automatic send_word(logic [BYTES_W-1:0] nbytes);
    in_valid_i      <= 1'b1;
    request_bytes_i <= nbytes;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i      <= 1'b0;
      request_bytes_i <= BYTES_W'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  function automatic logic [BYTES_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return '0;
    if (r < 65) return BYTES_W'($urandom_range(1, 256));
    if (r < 82) return BYTES_W'($urandom_range(257, 4096));
    if (r < 94) return BYTES_W'($urandom_range(4097, 32768));
    return BYTES_W'($urandom);
  endfunction

  initial begin
    logic [BYTES_W-1:0] edge_sizes [$];
    int                 n;
    int                 ph;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    request_bytes_i = '0;
    idle_pct        = 0;
    stall_pct       = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero, rounding, exact half space, oversize, then a run of small requests
    edge_sizes = '{16'd0, 16'd1, 16'd7, 16'd8, 16'd9, 16'hFFFF, 16'd32768,
                   16'd32769, 16'd1, 16'd0, 16'd32760, 16'd16, 16'd8};
    foreach (edge_sizes[i]) send_word(edge_sizes[i]);
    for (n = 0; n < 12; n++) send_word(16'd8);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      for (n = 0; n < 300; n++) send_word(pick_size());
    end
    in_valid_i <= 1'b0;
    stall_pct  = 0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0)
      $display("first_fit_semispace_allocator regression: pass");
    else
      $display("first_fit_semispace_allocator regression: fail");
    $finish;
  end

endmodule

@@ first_fit_semispace_allocator.f @@
+incdir+rtl
rtl/ffss_pkg.sv
rtl/ffss_space_ram.sv
rtl/first_fit_semispace_allocator.sv
tb/first_fit_semispace_allocator_checker.sv
tb/tb.sv
